// File: hw/rtl/sorted_linked_list_table_top_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the sorted linked list table
// Clocked on clk, disabled while arst_n is low.
// ---------------------------------------------------------------------------
`ifndef SORTED_LINKED_LIST_TABLE_TOP_MACROS_SVH
`define SORTED_LINKED_LIST_TABLE_TOP_MACROS_SVH

// same-cycle implication
`define SLLT_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SLLT_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hw/rtl/sllt_pkg.sv
// ---------------------------------------------------------------------------
// sllt_pkg
// Shared types and constants of the sorted linked list table.
// ---------------------------------------------------------------------------
`default_nettype none

package sllt_pkg;

	localparam int SLOTS_DEF = 16;
	localparam int VALUE_W   = 32;
	localparam int SLOT_W    = 4;
	localparam int ACTION_W  = 2;
	localparam int STATUS_W  = 3;

	typedef enum logic [ACTION_W-1:0] {
		ACT_INSERT = 2'd0,
		ACT_DELETE = 2'd1,
		ACT_WALK   = 2'd2
	} action_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_INSERTED  = 3'd0,
		ST_DELETED   = 3'd1,
		ST_NOT_FOUND = 3'd2,
		ST_FULL      = 3'd3,
		ST_ENTRY     = 3'd4,
		ST_EMPTY     = 3'd5
	} status_t;

endpackage

`default_nettype wire

// File: hw/rtl/sorted_linked_list_table_top.sv
// ---------------------------------------------------------------------------
// sorted_linked_list_table_top
// Sorted singly linked list of signed values held in a value RAM and a link
// RAM; slot 0 is the head, its link kept in a register.
// ---------------------------------------------------------------------------
// Use:
//   Command channel: an item (action, value) is taken at a clock edge with
//   start high and busy low. busy stays high while the item walks the list.
//   Result channel: done marks each result for one cycle; the receiver must
//   take it then, it cannot stall the block.
//   Steps: the item is taken, then each list entry is visited by one
//   registered read of both RAMs at the address the previous link gave.
//   An insert that links behind an existing entry goes on to S_FIX for the
//   second link write. Results are registered. A walk emits one entry per
//   cycle. Full table, empty list and a miss on an empty list answer from
//   S_IDLE without visiting the list.
//   Reset empties the list (head link null, next free slot 1) at once; no
//   clearing pass is needed. Deleted slots are not reused.
// ---------------------------------------------------------------------------
`default_nettype none

module sorted_linked_list_table_top #(
	parameter int SLOTS = sllt_pkg::SLOTS_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	output logic                                busy,
	input  wire logic [sllt_pkg::ACTION_W-1:0]  action,
	input  wire logic signed [sllt_pkg::VALUE_W-1:0] value,
	output logic                                done,
	output logic      [sllt_pkg::STATUS_W-1:0]  status,
	output logic      [sllt_pkg::SLOT_W-1:0]    slot,
	output logic signed [sllt_pkg::VALUE_W-1:0] entry_value,
	output logic                                last
);

	import sllt_pkg::*;

	localparam int SW    = $clog2(SLOTS);
	localparam int NFS_W = SW + 1;

	typedef logic [SW-1:0] idx_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_RUN,
		S_FIX
	} state_t;

	state_t                     state_q;
	action_t                    op_q;
	logic signed [VALUE_W-1:0]  val_q;
	idx_t                       cur_q;
	idx_t                       prev_q;
	idx_t                       ns_q;
	idx_t                       head_q;
	logic [NFS_W-1:0]           nfs_q;

	logic                       done_q;
	logic [STATUS_W-1:0]        status_q;
	logic [SLOT_W-1:0]          slot_q;
	logic signed [VALUE_W-1:0]  entry_value_q;
	logic                       last_q;

	logic                       accept;
	logic                       full;
	idx_t                       ns;
	logic [VALUE_W-1:0]         v_rdata;
	logic signed [VALUE_W-1:0]  vr;
	idx_t                       lr;
	idx_t                       raddr;
	logic                       v_we;
	logic                       l_we;
	idx_t                       l_waddr;
	idx_t                       l_wdata;
	logic                       lt;
	logic                       stop_ins;
	idx_t                       new_prev;
	idx_t                       new_cur;

	function automatic logic [SLOT_W-1:0] slot4(idx_t i);
		logic [SW+SLOT_W-1:0] e;
		e = {{SLOT_W{1'b0}}, i};
		return e[SLOT_W-1:0];
	endfunction

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;
	assign full   = (nfs_q >= NFS_W'(SLOTS));
	assign ns     = nfs_q[SW-1:0];
	assign vr     = $signed(v_rdata);
	assign raddr  = (state_q == S_IDLE) ? head_q : lr;

	// insert stops before the first entry not smaller, or after the tail
	assign lt       = (vr < val_q);
	assign stop_ins = !lt || (lr == '0);
	assign new_prev = lt ? cur_q : prev_q;
	assign new_cur  = lt ? idx_t'(0) : cur_q;

	assign v_we = accept && (action == ACT_INSERT) && !full;

	always_comb begin
		l_we    = 1'b0;
		l_waddr = ns_q;
		l_wdata = '0;
		case (state_q)
			S_IDLE: begin
				if (accept && (action == ACT_INSERT) && !full && (head_q == '0)) begin
					l_we    = 1'b1;
					l_waddr = ns;
					l_wdata = '0;
				end
			end
			S_RUN: begin
				if (op_q == ACT_INSERT && stop_ins) begin
					l_we    = 1'b1;
					l_waddr = ns_q;
					l_wdata = new_cur;
				end else if (op_q == ACT_DELETE && vr == val_q && prev_q != '0) begin
					l_we    = 1'b1;
					l_waddr = prev_q;
					l_wdata = lr;
				end
			end
			S_FIX: begin
				l_we    = 1'b1;
				l_waddr = prev_q;
				l_wdata = ns_q;
			end
			default: begin
				l_we = 1'b0;
			end
		endcase
	end

	sllt_ram #(
		.WIDTH (VALUE_W),
		.DEPTH (SLOTS)
	) u_values (
		.clk   (clk),
		.we    (v_we),
		.waddr (ns),
		.wdata (value),
		.raddr (raddr),
		.rdata (v_rdata)
	);

	sllt_ram #(
		.WIDTH (SW),
		.DEPTH (SLOTS)
	) u_links (
		.clk   (clk),
		.we    (l_we),
		.waddr (l_waddr),
		.wdata (l_wdata),
		.raddr (raddr),
		.rdata (lr)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			head_q  <= '0;
			nfs_q   <= NFS_W'(1);
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						op_q   <= action_t'(action);
						val_q  <= value;
						cur_q  <= head_q;
						prev_q <= '0;
						case (action)
							ACT_INSERT: begin
								if (full) begin
									done_q        <= 1'b1;
									status_q      <= ST_FULL;
									slot_q        <= '0;
									entry_value_q <= '0;
									last_q        <= 1'b1;
								end else begin
									nfs_q <= nfs_q + NFS_W'(1);
									ns_q  <= ns;
									if (head_q == '0) begin
										head_q        <= ns;
										done_q        <= 1'b1;
										status_q      <= ST_INSERTED;
										slot_q        <= slot4(ns);
										entry_value_q <= value;
										last_q        <= 1'b1;
									end else begin
										state_q <= S_RUN;
									end
								end
							end
							ACT_DELETE: begin
								if (head_q == '0) begin
									done_q        <= 1'b1;
									status_q      <= ST_NOT_FOUND;
									slot_q        <= '0;
									entry_value_q <= '0;
									last_q        <= 1'b1;
								end else begin
									state_q <= S_RUN;
								end
							end
							ACT_WALK: begin
								if (head_q == '0) begin
									done_q        <= 1'b1;
									status_q      <= ST_EMPTY;
									slot_q        <= '0;
									entry_value_q <= '0;
									last_q        <= 1'b1;
								end else begin
									state_q <= S_RUN;
								end
							end
							default: begin
								state_q <= S_IDLE;
							end
						endcase
					end
				end
				S_RUN: begin
					case (op_q)
						ACT_INSERT: begin
							if (stop_ins) begin
								if (new_prev == '0) begin
									head_q        <= ns_q;
									done_q        <= 1'b1;
									status_q      <= ST_INSERTED;
									slot_q        <= slot4(ns_q);
									entry_value_q <= val_q;
									last_q        <= 1'b1;
									state_q       <= S_IDLE;
								end else begin
									prev_q  <= new_prev;
									state_q <= S_FIX;
								end
							end else begin
								prev_q <= cur_q;
								cur_q  <= lr;
							end
						end
						ACT_DELETE: begin
							if (vr == val_q) begin
								if (prev_q == '0) begin
									head_q <= lr;
								end
								done_q        <= 1'b1;
								status_q      <= ST_DELETED;
								slot_q        <= slot4(cur_q);
								entry_value_q <= vr;
								last_q        <= 1'b1;
								state_q       <= S_IDLE;
							end else if (lr == '0) begin
								done_q        <= 1'b1;
								status_q      <= ST_NOT_FOUND;
								slot_q        <= '0;
								entry_value_q <= '0;
								last_q        <= 1'b1;
								state_q       <= S_IDLE;
							end else begin
								prev_q <= cur_q;
								cur_q  <= lr;
							end
						end
						ACT_WALK: begin
							done_q        <= 1'b1;
							status_q      <= ST_ENTRY;
							slot_q        <= slot4(cur_q);
							entry_value_q <= vr;
							last_q        <= (lr == '0);
							cur_q         <= lr;
							if (lr == '0) begin
								state_q <= S_IDLE;
							end
						end
						default: begin
							state_q <= S_IDLE;
						end
					endcase
				end
				S_FIX: begin
					done_q        <= 1'b1;
					status_q      <= ST_INSERTED;
					slot_q        <= slot4(ns_q);
					entry_value_q <= val_q;
					last_q        <= 1'b1;
					state_q       <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign done        = done_q;
	assign status      = status_q;
	assign slot        = slot_q;
	assign entry_value = entry_value_q;
	assign last        = last_q;

endmodule

`default_nettype wire

// File: hw/rtl/sllt_ram.sv
// ---------------------------------------------------------------------------
// sllt_ram
// Generic one-write, one-read RAM with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module sllt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// File: hw/rtl/sllt_checker.sv
// ---------------------------------------------------------------------------
// sllt_checker
// Port-level checks on the sorted linked list table, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "sorted_linked_list_table_top_macros.svh"

module sllt_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          start,
	input wire logic                          busy,
	input wire logic [sllt_pkg::ACTION_W-1:0] action,
	input wire logic                          done,
	input wire logic [sllt_pkg::STATUS_W-1:0] status,
	input wire logic [sllt_pkg::SLOT_W-1:0]   slot,
	input wire logic [sllt_pkg::VALUE_W-1:0]  entry_value,
	input wire logic                          last
);

	import sllt_pkg::*;

	// an unknown action is dropped without a result
	`SLLT_ASSERT_NXT(a_unused_silent, start && !busy && action != ACT_INSERT && action != ACT_DELETE && action != ACT_WALK, !done, "unknown action gave a result")

	// walk entries come back to back until the last one
	`SLLT_ASSERT_NXT(a_walk_gapless, done && !last, done && status == ST_ENTRY, "gap in walk results")

	// the final result of an item leaves the block free
	`SLLT_ASSERT_IMP(a_last_idle, done && last, !busy, "busy after final result")

	// results that name no slot carry zeros
	`SLLT_ASSERT_IMP(a_no_slot_zero, done && (status == ST_NOT_FOUND || status == ST_FULL || status == ST_EMPTY), slot == '0 && entry_value == '0 && last, "slot-less result not zeroed")

endmodule

bind sorted_linked_list_table_top sllt_checker u_sllt_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.action      (action),
	.done        (done),
	.status      (status),
	.slot        (slot),
	.entry_value (entry_value),
	.last        (last)
);

`default_nettype wire

// File: tb/tb.sv
// ---------------------------------------------------------------------------
// tb
// Drives insert, delete and walk commands into the sorted linked list table,
// tracks the list in a local model and checks every strobed result against
// it, field by field and in order.
// ---------------------------------------------------------------------------
`default_nettype none

module tb;

	timeunit 1ns;
	timeprecision 1ps;

	import sllt_pkg::*;

	localparam int TABLE_SLOTS = SLOTS_DEF;
	localparam int LINK_W      = $clog2(TABLE_SLOTS) + 1;
	localparam int RAND_ITEMS  = 95;
	localparam int DRAIN_WAIT  = 2 * TABLE_SLOTS + 8;
	localparam int CYCLE_LIMIT = 200000;
	localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

	typedef struct packed {
		logic [ACTION_W-1:0]       op;
		logic signed [VALUE_W-1:0] val;
	} list_cmd_t;

	typedef struct packed {
		status_t                   status;
		logic [SLOT_W-1:0]         slot;
		logic signed [VALUE_W-1:0] val;
		logic                      last;
	} list_result_t;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       start = 1'b0;
	logic [ACTION_W-1:0]        action = '0;
	logic signed [VALUE_W-1:0]  value = '0;
	logic                       busy;
	logic                       done;
	logic [STATUS_W-1:0]        status;
	logic [SLOT_W-1:0]          slot;
	logic signed [VALUE_W-1:0]  entry_value;
	logic                       last;

	sorted_linked_list_table_top dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.action      (action),
		.value       (value),
		.done        (done),
		.status      (status),
		.slot        (slot),
		.entry_value (entry_value),
		.last        (last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// model of the list tables
	logic signed [VALUE_W-1:0] model_vals  [TABLE_SLOTS];
	logic [LINK_W-1:0]         model_links [TABLE_SLOTS];
	int unsigned               model_free = 1;

	list_cmd_t    pending_cmds[$];
	list_result_t list_expect[$];
	logic signed [VALUE_W-1:0] gen_live[$];
	int gen_inserts = 0;

	int issued_cnt = 0;
	int taken_cnt = 0;
	int idle_left = 0;
	int gap_mode = 0;
	int result_cnt = 0;
	int mismatch_cnt = 0;
	int cycle_cnt = 0;
	int status_seen[8];

	initial model_links[0] = '0;

	task automatic predict_list_op(input logic [ACTION_W-1:0] op,
			input logic signed [VALUE_W-1:0] v);
		int unsigned prev_s;
		int unsigned cur_s;
		int unsigned nx;
		int unsigned steps;
		int n;
		logic fin;
		prev_s = 0;
		case (op)
			ACT_INSERT: begin
				if (model_free >= TABLE_SLOTS) begin
					list_expect.push_back('{ST_FULL, '0, '0, 1'b1});
				end else begin
					model_vals[model_free] = v;
					cur_s = model_links[0];
					steps = 0;
					// stop in front of the first entry that is not smaller
					while (cur_s != 0 && steps < TABLE_SLOTS && model_vals[cur_s] < v) begin
						prev_s = cur_s;
						cur_s = model_links[cur_s];
						steps++;
					end
					model_links[prev_s] = LINK_W'(model_free);
					model_links[model_free] = LINK_W'(cur_s);
					list_expect.push_back('{ST_INSERTED, SLOT_W'(model_free), v, 1'b1});
					model_free++;
				end
			end
			ACT_DELETE: begin
				cur_s = model_links[0];
				steps = 0;
				while (cur_s != 0 && steps < TABLE_SLOTS && model_vals[cur_s] != v) begin
					prev_s = cur_s;
					cur_s = model_links[cur_s];
					steps++;
				end
				if (cur_s != 0 && steps < TABLE_SLOTS) begin
					model_links[prev_s] = model_links[cur_s];
					list_expect.push_back('{ST_DELETED, SLOT_W'(cur_s), model_vals[cur_s],
						1'b1});
				end else begin
					list_expect.push_back('{ST_NOT_FOUND, '0, '0, 1'b1});
				end
			end
			ACT_WALK: begin
				cur_s = model_links[0];
				if (cur_s == 0) begin
					list_expect.push_back('{ST_EMPTY, '0, '0, 1'b1});
				end else begin
					n = 0;
					while (cur_s != 0 && n < TABLE_SLOTS - 1) begin
						nx = model_links[cur_s];
						fin = (nx == 0) || (n + 1 >= TABLE_SLOTS - 1);
						list_expect.push_back('{ST_ENTRY, SLOT_W'(cur_s), model_vals[cur_s],
							fin});
						n++;
						cur_s = nx;
					end
				end
			end
			default: begin
			end
		endcase
	endtask

	// queues a command and keeps track of which values should be in the list
	function automatic void add_cmd(input logic [ACTION_W-1:0] op,
			input logic signed [VALUE_W-1:0] v);
		pending_cmds.push_back('{op, v});
		if (op == ACT_INSERT && gen_inserts < TABLE_SLOTS - 1) begin
			gen_live.push_back(v);
			gen_inserts++;
		end else if (op == ACT_DELETE) begin
			foreach (gen_live[i]) begin
				if (gen_live[i] == v) begin
					gen_live.delete(i);
					break;
				end
			end
		end
	endfunction

	function automatic logic signed [VALUE_W-1:0] rand_value();
		// small values often, so that duplicates turn up
		if ($urandom_range(0, 1) == 0)
			return $signed(VALUE_W'($urandom_range(0, 8))) - 4;
		return $urandom;
	endfunction

	// driver: changes inputs on the falling edge
	always @(negedge clk) begin
		list_cmd_t c;
		if (!arst_n) begin
			start <= 1'b0;
		end else if (issued_cnt == taken_cnt) begin
			if (idle_left > 0) begin
				idle_left <= idle_left - 1;
				start <= 1'b0;
				action <= ACTION_W'($urandom);
				value <= $urandom;
			end else if (pending_cmds.size() > 0) begin
				c = pending_cmds.pop_front();
				start <= 1'b1;
				action <= c.op;
				value <= c.val;
				if (issued_cnt % 16 == 0)
					gap_mode <= $urandom_range(0, 2);
				idle_left <= (gap_mode == 0) ? 0 : $urandom_range(0, 17);
				issued_cnt <= issued_cnt + 1;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// monitor: samples on the rising edge
	always @(posedge clk) begin
		list_result_t e;
		if (arst_n) begin
			if (done) begin
				result_cnt++;
				status_seen[status]++;
				if (list_expect.size() == 0) begin
					mismatch_cnt++;
					if (mismatch_cnt <= 10)
						$display("unexpected result: status %0d slot %0d value %0d last %0b",
							status, slot, entry_value, last);
				end else begin
					e = list_expect.pop_front();
					if (status !== e.status || slot !== e.slot || entry_value !== e.val ||
							last !== e.last) begin
						mismatch_cnt++;
						if (mismatch_cnt <= 10)
							$display("mismatch: got status %0d slot %0d value %0d last %0b, %s",
								status, slot, entry_value, last,
								$sformatf("expected status %0d slot %0d value %0d last %0b",
									e.status, e.slot, e.val, e.last));
					end
				end
			end
			if (start && !busy) begin
				taken_cnt <= taken_cnt + 1;
				predict_list_op(action, value);
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_cnt);
			$display("tb failed");
			$finish;
		end
	end

	initial begin
		int n_items;
		int r;
		logic signed [VALUE_W-1:0] v;

		// empty list, miss on empty list, unused action
		add_cmd(ACT_WALK, $urandom);
		add_cmd(ACT_DELETE, 32'sd7);
		add_cmd(ACT_UNUSED, $urandom);
		// extremes and duplicates; equal values go in front of older ones
		add_cmd(ACT_INSERT, 32'sd0);
		add_cmd(ACT_INSERT, 32'sh7fffffff);
		add_cmd(ACT_INSERT, 32'sh80000000);
		add_cmd(ACT_INSERT, -32'sd1);
		add_cmd(ACT_INSERT, 32'sd0);
		add_cmd(ACT_INSERT, 32'sd1);
		add_cmd(ACT_INSERT, 32'sh7fffffff);
		add_cmd(ACT_INSERT, 32'sh80000000);
		add_cmd(ACT_WALK, $urandom);
		// fill the table, then walk all entries and hit the full case
		repeat (TABLE_SLOTS - 1 - 8)
			add_cmd(ACT_INSERT, rand_value());
		add_cmd(ACT_WALK, $urandom);
		add_cmd(ACT_INSERT, 32'sd2);
		add_cmd(ACT_DELETE, 32'sd0);
		add_cmd(ACT_DELETE, 32'sh12345678);
		add_cmd(ACT_DELETE, 32'sh80000000);
		add_cmd(ACT_DELETE, 32'sh7fffffff);
		add_cmd(ACT_WALK, $urandom);

		// random part: deletes mostly of values still held, walks, full inserts
		n_items = 0;
		while (n_items < RAND_ITEMS) begin
			r = $urandom_range(0, 99);
			if (r < 8) begin
				add_cmd(ACT_UNUSED, $urandom);
			end else begin
				if (r < 25) begin
					add_cmd(ACT_INSERT, rand_value());
				end else if (r < 60) begin
					if (gen_live.size() > 0 && $urandom_range(0, 4) != 0)
						v = gen_live[$urandom_range(0, gen_live.size() - 1)];
					else
						v = rand_value();
					add_cmd(ACT_DELETE, v);
				end else begin
					add_cmd(ACT_WALK, $urandom);
				end
				n_items++;
			end
		end

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (pending_cmds.size() > 0 || issued_cnt != taken_cnt || list_expect.size() > 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		if (list_expect.size() > 0)
			mismatch_cnt++;
		$display("%0d items taken, %0d results checked, %0d failures",
			taken_cnt, result_cnt, mismatch_cnt);
		$display("inserted %0d, deleted %0d, not found %0d, full %0d, entries %0d, empty %0d",
			status_seen[ST_INSERTED], status_seen[ST_DELETED], status_seen[ST_NOT_FOUND],
			status_seen[ST_FULL], status_seen[ST_ENTRY], status_seen[ST_EMPTY]);
		if (mismatch_cnt == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

endmodule

`default_nettype wire
